FILE: design/bfba_pkg.sv
// ============================================================================
// bfba_pkg
// Shared types and constants for the best-fit block allocator.
// ============================================================================
`default_nettype none

package bfba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_W     = 16;
    localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int FIELD_W    = 16;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    // request travelling down the cell chain with the best fit so far
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] req;
        logic              hit;
        logic [SIZE_W-1:0] best_left;
        logic [BLK_W-1:0]  best_idx;
        logic [SIZE_W-1:0] best_orig;
    } t_scan;

    // write broadcast to all cells
    typedef struct packed {
        logic              en;
        logic              load;
        logic [BLK_W-1:0]  idx;
        logic [SIZE_W-1:0] data;
    } t_wr;

endpackage

`default_nettype wire

FILE: design/best_fit_block_allocator.sv
// ============================================================================
// best_fit_block_allocator
// Best-fit allocator over a table of free blocks kept in a chain of cells.
// ============================================================================
// Load items write one block's size and are taken one per cycle, back to back,
// while no allocation is in flight. An allocation item runs down the chain of
// MAX_BLOCKS cells, one cell per cycle, and then writes the leftover back once
// the result register is free (S_DONE); no new item is taken until that
// write. Only allocations return a result item. The table and block_count
// clear at reset.
`default_nettype none

module best_fit_block_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [bfba_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire logic                        i_mode,
    input  wire logic [bfba_pkg::IDX_W-1:0]  i_block_index,
    input  wire logic [bfba_pkg::FIELD_W-1:0] i_size_value,
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      logic                        o_found,
    output      logic [bfba_pkg::IDX_W-1:0]  o_chosen_block,
    output      logic [bfba_pkg::FIELD_W-1:0] o_original_size,
    output      logic [bfba_pkg::FIELD_W-1:0] o_leftover
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [bfba_pkg::CNT_W-1:0]    r_count;
    bfba_pkg::t_scan               r_res;
    logic                          r_out_valid;
    logic                          r_found;
    logic [bfba_pkg::IDX_W-1:0]    r_chosen;
    logic [bfba_pkg::FIELD_W-1:0]  r_orig;
    logic [bfba_pkg::FIELD_W-1:0]  r_left;

    bfba_pkg::t_scan               tok_chain [bfba_pkg::MAX_BLOCKS];
    logic [bfba_pkg::MAX_BLOCKS-1:0] chain_vld;
    bfba_pkg::t_scan               launch;
    bfba_pkg::t_wr                 wr;
    logic                          accept;
    logic                          out_free;
    logic                          done_fire;
    logic [bfba_pkg::SIZE_W-1:0]   size_in;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign done_fire  = (r_state == S_DONE) && out_free;
    assign size_in    = bfba_pkg::SIZE_W'(i_size_value);

    always_comb begin
        launch           = '0;
        launch.valid     = accept && (i_mode == bfba_pkg::MODE_ALLOC);
        launch.req       = size_in;
    end

    always_comb begin
        wr = '0;
        if (accept && (i_mode == bfba_pkg::MODE_LOAD)) begin
            wr.en   = (32'(i_block_index) < 32'(bfba_pkg::MAX_BLOCKS));
            wr.load = 1'b1;
            wr.idx  = bfba_pkg::BLK_W'(i_block_index);
            wr.data = size_in;
        end else if (done_fire && r_res.hit) begin
            wr.en   = 1'b1;
            wr.load = 1'b0;
            wr.idx  = r_res.best_idx;
            wr.data = r_res.best_left;
        end
    end

    for (genvar j = 0; j < bfba_pkg::MAX_BLOCKS; j++) begin : g_cell
        bfba_pkg::t_scan tok_in;
        if (j == 0) begin : g_head
            assign tok_in = launch;
        end else begin : g_body
            assign tok_in = tok_chain[j-1];
        end
        bfba_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (bfba_pkg::BLK_W'(j)),
            .i_active   (32'(r_count) > 32'(j)),
            .i_wr       (wr),
            .i_tok      (tok_in),
            .o_tok      (tok_chain[j])
        );
        assign chain_vld[j] = tok_chain[j].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (launch.valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tok_chain[bfba_pkg::MAX_BLOCKS-1].valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if ((r_state == S_SCAN) && tok_chain[bfba_pkg::MAX_BLOCKS-1].valid) begin
            r_res <= tok_chain[bfba_pkg::MAX_BLOCKS-1];
        end
        if (done_fire) begin
            r_found <= r_res.hit;
            if (r_res.hit) begin
                r_chosen <= bfba_pkg::IDX_W'(r_res.best_idx);
                r_orig   <= bfba_pkg::FIELD_W'(r_res.best_orig);
                r_left   <= bfba_pkg::FIELD_W'(r_res.best_left);
            end else begin
                r_chosen <= '0;
                r_orig   <= '0;
                r_left   <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_chosen_block  = r_chosen;
    assign o_original_size = r_orig;
    assign o_leftover      = r_left;

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(chain_vld))
        else $error("more than one request in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (chain_vld == '0))
        else $error("request in the chain while idle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
        (o_chosen_block == '0 && o_original_size == '0 && o_leftover == '0))
        else $error("no-fit item carries nonzero fields");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_leftover <= o_original_size))
        else $error("leftover exceeds original size");

endmodule

`default_nettype wire

FILE: design/bfba_cell.sv
// ============================================================================
// bfba_cell
// One block of the free table: holds current and original size, checks the
// passing request against its size and hands the best fit to the next cell.
// ============================================================================
`default_nettype none

module bfba_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [bfba_pkg::BLK_W-1:0] i_cell_idx,
    input  wire logic                       i_active,
    input  wire bfba_pkg::t_wr              i_wr,
    input  wire bfba_pkg::t_scan            i_tok,
    output      bfba_pkg::t_scan            o_tok
);

    logic [bfba_pkg::SIZE_W-1:0] r_cur;
    logic [bfba_pkg::SIZE_W-1:0] r_orig;
    bfba_pkg::t_scan             r_tok;
    bfba_pkg::t_scan             n_tok;
    logic [bfba_pkg::SIZE_W-1:0] left;
    logic                        fits;
    logic                        take;
    logic                        wr_hit;

    assign left   = r_cur - i_tok.req;
    assign fits   = i_tok.valid && i_active && (r_cur >= i_tok.req);
    assign take   = fits && (!i_tok.hit || (left <= i_tok.best_left));
    assign wr_hit = i_wr.en && (i_wr.idx == i_cell_idx);

    always_comb begin
        n_tok = i_tok;
        if (take) begin
            n_tok.hit       = 1'b1;
            n_tok.best_left = left;
            n_tok.best_idx  = i_cell_idx;
            n_tok.best_orig = r_orig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_orig      <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            if (wr_hit) begin
                r_cur <= i_wr.data;
                if (i_wr.load) begin
                    r_orig <= i_wr.data;
                end
            end
            r_tok.valid <= n_tok.valid;
        end
        r_tok.req       <= n_tok.req;
        r_tok.hit       <= n_tok.hit;
        r_tok.best_left <= n_tok.best_left;
        r_tok.best_idx  <= n_tok.best_idx;
        r_tok.best_orig <= n_tok.best_orig;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: bench/bfba_fit_checker.sv
// ============================================================================
// bfba_fit_checker
// Watches the allocator's channels, predicts every allocation result from
// its own copy of the block table and block count, and compares each
// accepted result field by field with the oldest prediction.
// ============================================================================

module bfba_fit_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bfba_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_mode,
    input  logic [bfba_pkg::IDX_W-1:0]   i_block_index,
    input  logic [bfba_pkg::FIELD_W-1:0] i_size_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_found,
    input  logic [bfba_pkg::IDX_W-1:0]   i_chosen_block,
    input  logic [bfba_pkg::FIELD_W-1:0] i_original_size,
    input  logic [bfba_pkg::FIELD_W-1:0] i_leftover,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                         found;
        logic [bfba_pkg::IDX_W-1:0]   blk;
        logic [bfba_pkg::FIELD_W-1:0] orig;
        logic [bfba_pkg::FIELD_W-1:0] left;
    } t_grant;

    logic [bfba_pkg::SIZE_W-1:0] cur_size  [bfba_pkg::MAX_BLOCKS];
    logic [bfba_pkg::SIZE_W-1:0] orig_size [bfba_pkg::MAX_BLOCKS];
    logic [bfba_pkg::CNT_W-1:0]  blocks_in_use;
    t_grant                      expected_grants [$];
    int                          mismatches;

    function automatic t_grant best_fit(input logic [bfba_pkg::SIZE_W-1:0] req);
        t_grant                      g;
        int                          limit;
        int                          best;
        logic                        hit;
        logic [bfba_pkg::SIZE_W-1:0] best_left;
        logic [bfba_pkg::SIZE_W-1:0] left_j;
        g         = '0;
        hit       = 1'b0;
        best      = 0;
        best_left = '0;
        limit = (int'(blocks_in_use) > bfba_pkg::MAX_BLOCKS) ?
                bfba_pkg::MAX_BLOCKS : int'(blocks_in_use);
        for (int j = 0; j < limit; j++) begin
            if (cur_size[j] >= req) begin
                left_j = cur_size[j] - req;
                if (!hit || left_j <= best_left) begin
                    hit       = 1'b1;
                    best_left = left_j;
                    best      = j;
                end
            end
        end
        if (hit) begin
            g.found = 1'b1;
            g.blk   = bfba_pkg::IDX_W'(best);
            g.orig  = bfba_pkg::FIELD_W'(orig_size[best]);
            g.left  = bfba_pkg::FIELD_W'(best_left);
        end
        return g;
    endfunction

    always @(posedge i_clk) begin : watch
        t_grant got;
        t_grant want;
        logic [bfba_pkg::SIZE_W-1:0] sz;
        if (!i_rst_n) begin
            for (int j = 0; j < bfba_pkg::MAX_BLOCKS; j++) begin
                cur_size[j]  = '0;
                orig_size[j] = '0;
            end
            blocks_in_use = '0;
            expected_grants.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_found, i_chosen_block, i_original_size, i_leftover};
                if (expected_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"unexpected result: expected none, got found=%0d ",
                                  "block=%0d orig=%0d left=%0d"},
                                 got.found, got.blk, got.orig, got.left);
                end else begin
                    want = expected_grants.pop_front();
                    if (got.found !== want.found || got.blk !== want.blk ||
                        got.orig !== want.orig || got.left !== want.left) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"result mismatch: expected found=%0d block=%0d ",
                                      "orig=%0d left=%0d, got found=%0d block=%0d ",
                                      "orig=%0d left=%0d"},
                                     want.found, want.blk, want.orig, want.left,
                                     got.found, got.blk, got.orig, got.left);
                    end
                end
            end
            if (i_cfg_wr_en)
                blocks_in_use = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) begin
                sz = i_size_value[bfba_pkg::SIZE_W-1:0];
                if (i_mode == bfba_pkg::MODE_LOAD) begin
                    if (int'(i_block_index) < bfba_pkg::MAX_BLOCKS) begin
                        cur_size[i_block_index]  = sz;
                        orig_size[i_block_index] = sz;
                    end
                end else begin
                    want = best_fit(sz);
                    if (want.found)
                        cur_size[want.blk] = want.left[bfba_pkg::SIZE_W-1:0];
                    expected_grants.push_back(want);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_grants.size();
    end

endmodule

FILE: bench/tb_best_fit_block_allocator.sv
// ============================================================================
// tb_best_fit_block_allocator
// Drives load and allocation items into the best-fit allocator under several
// block counts and idle patterns; the checker predicts and compares results.
// ============================================================================

module tb_best_fit_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE      = 24;
    localparam int PHASE_ITEMS = 230;
    localparam int NUM_PHASES  = 8;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_cfg_wr_en    = 1'b0;
    logic [bfba_pkg::CNT_W-1:0]   i_cfg_wr_data  = '0;
    logic                         i_in_valid     = 1'b0;
    logic                         i_mode         = bfba_pkg::MODE_LOAD;
    logic [bfba_pkg::IDX_W-1:0]   i_block_index  = '0;
    logic [bfba_pkg::FIELD_W-1:0] i_size_value   = '0;
    logic                         i_out_ready    = 1'b0;

    logic                         o_in_ready;
    logic                         o_out_valid;
    logic                         o_found;
    logic [bfba_pkg::IDX_W-1:0]   o_chosen_block;
    logic [bfba_pkg::FIELD_W-1:0] o_original_size;
    logic [bfba_pkg::FIELD_W-1:0] o_leftover;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int phase_counts [NUM_PHASES] = '{16, 31, 1, 17, 2, 16, 8, 0};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    best_fit_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_block_index  (i_block_index),
        .i_size_value   (i_size_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_chosen_block (o_chosen_block),
        .o_original_size(o_original_size),
        .o_leftover     (o_leftover)
    );

    bfba_fit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_block_index  (i_block_index),
        .i_size_value   (i_size_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_found        (o_found),
        .i_chosen_block (o_chosen_block),
        .i_original_size(o_original_size),
        .i_leftover     (o_leftover),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_best_fit_block_allocator NOT OK");
            $finish;
        end
    end

    function automatic logic [bfba_pkg::FIELD_W-1:0] draw_size();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return bfba_pkg::FIELD_W'($urandom_range(63));
            6:                return bfba_pkg::FIELD_W'($urandom_range(65535));
            7:                return bfba_pkg::FIELD_W'(65535 - $urandom_range(3));
            8:                return bfba_pkg::FIELD_W'($urandom_range(4095));
            default:          return '0;
        endcase
    endfunction

    task automatic send_item(input logic m, input logic [bfba_pkg::IDX_W-1:0] idx,
                             input logic [bfba_pkg::FIELD_W-1:0] sz);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= m;
        i_block_index <= idx;
        i_size_value  <= sz;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_count(input int cnt);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= bfba_pkg::CNT_W'(cnt);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no blocks scanned
        set_count(0);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'd0);
        send_item(bfba_pkg::MODE_ALLOC, 4'd15, 16'hFFFF);

        // never loaded blocks, tie-breaks, exact and oversized fits
        set_count(16);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'd0);
        send_item(bfba_pkg::MODE_LOAD, 4'd0, 16'hFFFF);
        send_item(bfba_pkg::MODE_LOAD, 4'd15, 16'd0);
        send_item(bfba_pkg::MODE_LOAD, 4'd7, 16'd100);
        send_item(bfba_pkg::MODE_LOAD, 4'd3, 16'd100);
        send_item(bfba_pkg::MODE_LOAD, 4'd9, 16'hAAAA);
        send_item(bfba_pkg::MODE_LOAD, 4'd10, 16'h5555);
        send_item(bfba_pkg::MODE_ALLOC, 4'd5, 16'd100);
        send_item(bfba_pkg::MODE_ALLOC, 4'd10, 16'd100);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'd100);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'hFFFF);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'hFFFF);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'd0);
        send_item(bfba_pkg::MODE_LOAD, 4'd12, 16'd200);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'd50);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'd150);
        send_item(bfba_pkg::MODE_LOAD, 4'd4, 16'hFFFF);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'h8000);
        send_item(bfba_pkg::MODE_ALLOC, 4'd0, 16'h7FFF);

        phase_counts[NUM_PHASES-1] = $urandom_range(31);
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1:       begin send_idle_pct = 87; recv_stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct <= 87; end
                default: begin send_idle_pct = 28; recv_stall_pct <= 28; end
            endcase
            set_count(phase_counts[p]);
            for (int b = 0; b < bfba_pkg::MAX_BLOCKS; b++)
                send_item(bfba_pkg::MODE_LOAD, bfba_pkg::IDX_W'(b), draw_size());
            for (int n = bfba_pkg::MAX_BLOCKS; n < PHASE_ITEMS; n++)
                send_item(($urandom_range(99) < 40) ?
                              bfba_pkg::MODE_LOAD : bfba_pkg::MODE_ALLOC,
                          bfba_pkg::IDX_W'($urandom_range(15)), draw_size());
        end

        wait_idle();
        if (fail_count == 0)
            $display("tb_best_fit_block_allocator OK");
        else
            $display("tb_best_fit_block_allocator NOT OK");
        $finish;
    end

endmodule

FILE: files.f
design/bfba_pkg.sv
design/bfba_cell.sv
design/best_fit_block_allocator.sv
bench/bfba_fit_checker.sv
bench/tb_best_fit_block_allocator.sv
